[sv/rsws_pkg.sv]
// Shared types, codes and constants of the restricted shell word splitter.
`timescale 1ns / 1ps

package rsws_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_WEND   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_ACCEPT = 2'd3;

    // Error codes
    localparam logic [3:0] ERR_EXPANSION   = 4'd0;
    localparam logic [3:0] ERR_TRAIL_ESC   = 4'd1;
    localparam logic [3:0] ERR_CONTINUE    = 4'd2;
    localparam logic [3:0] ERR_SEMANTICS   = 4'd3;
    localparam logic [3:0] ERR_UNTERM      = 4'd4;
    localparam logic [3:0] ERR_COUNT       = 4'd5;
    localparam logic [3:0] ERR_BYTES       = 4'd6;
    localparam logic [3:0] ERR_NUL         = 4'd7;
    localparam logic [3:0] ERR_METADATA    = 4'd8;
    localparam logic [3:0] ERR_COMPILER    = 4'd9;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_WORDS      = 2'd0;
    localparam logic [1:0] CFG_MAX_WORD_BYTES = 2'd1;
    localparam logic [1:0] CFG_BUDGET         = 2'd2;

    localparam logic [15:0] MAX_WORDS_RESET      = 16'd1024;
    localparam logic [19:0] MAX_WORD_BYTES_RESET = 20'd65536;
    localparam logic [31:0] BUDGET_RESET         = 32'd16777216;

    // Word length saturates at 2^20
    localparam int unsigned LEN_W = 21;
    localparam logic [LEN_W-1:0] LEN_CAP = 21'h100000;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Result slots inside one bundle, in output order
    localparam int unsigned SLOT_BYTE0 = 0;
    localparam int unsigned SLOT_BYTE1 = 1;
    localparam int unsigned SLOT_WEND  = 2;
    localparam int unsigned SLOT_FINAL = 3;
    localparam int unsigned NSLOTS     = 4;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       end_of_command;
    } rsws_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] word_index;
        logic [3:0]  fault_code;
        logic        last;
    } rsws_out_t;

    // All results caused by one input item
    typedef struct packed {
        logic [NSLOTS-1:0] slots;
        logic [7:0]        byte0;
        logic [7:0]        byte1;
        logic [15:0]       word_index;
        logic              final_error;
        logic [3:0]        fault_code;
    } rsws_bundle_t;

endpackage

[sv/restricted_shell_word_splitter.sv]
// Top level of the restricted shell word splitter: front, bundle queue and back.
// A result passes through the bundle queue before it appears on the result ports.
// Throughput: one item per cycle while the queue has room; the back hands out one
// result per cycle while the consumer pops, so an item that causes k results takes k pops.
// Reset: rst_n clears the command state, the queue and the register values to defaults.
`timescale 1ns / 1ps

module restricted_shell_word_splitter
    import rsws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // item side
    input  logic        push,
    output logic        full,
    input  rsws_in_t    cmd_item,
    // result side
    output logic        empty,
    input  logic        pop,
    output rsws_out_t   result,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic         take;
    logic         bundle_valid;
    rsws_bundle_t bundle;
    rsws_bundle_t head;
    logic         head_done;

    // Registers can be written in any cycle.
    assign cfg_ready = 1'b1;

    // An item is taken whenever the queue has room, even if results still wait.
    assign take = push && !full;

    // Front: decode the byte, update the word and command state, and build the
    // bundle of up to four results (two bytes, a word end, an error or accept).
    rsws_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .cmd_item     (cmd_item),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .bundle_valid (bundle_valid),
        .bundle       (bundle)
    );

    // Queue: hold bundles so the front keeps running while the consumer stalls.
    // Items that cause no result never enter it.
    rsws_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bundle_valid),
        .wr_data (bundle),
        .rd_en   (head_done),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    // Back: advance through the head bundle's results one pop at a time and
    // drop the bundle once its last result is taken.
    rsws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!empty),
        .head       (head),
        .pop        (pop),
        .result     (result),
        .head_done  (head_done)
    );

endmodule

[sv/rsws_front.sv]
// Front part: decodes each input item, keeps the command state, builds result bundles.
`timescale 1ns / 1ps

module rsws_front
    import rsws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  rsws_in_t     cmd_item,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output logic         bundle_valid,
    output rsws_bundle_t bundle
);

    typedef enum logic [1:0] {Q_UNQUOTED, Q_SINGLE, Q_DOUBLE} quote_t;
    typedef enum logic [1:0] {ESC_NONE, ESC_PLAIN, ESC_DOUBLE} esc_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_BS    = 8'h5C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BTICK = 8'h60;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;

    logic [15:0]      max_words_reg;
    logic [19:0]      max_word_bytes_reg;
    logic [31:0]      budget_reg;

    quote_t           quote_reg, quote_next;
    esc_t             esc_reg, esc_next;
    logic             wopen_reg, wopen_next;
    logic [LEN_W-1:0] wlen_reg, wlen_next;
    logic             wnul_reg, wnul_next;
    logic [15:0]      wdone_reg, wdone_next;
    logic [31:0]      bused_reg, bused_next;
    logic             fwe_reg, fwe_next;
    logic             skip_reg, skip_next;

    logic [7:0]       c;
    logic [1:0]       nbytes;
    logic [7:0]       b0, b1;
    logic             err_v;
    logic [3:0]       err_c;
    logic             fin_req;
    logic             wend;
    logic             accept;
    logic [LEN_W-1:0] wlen_sum, wlen_e;
    logic             wnul_e;
    logic [31:0]      remaining;
    logic             is_space, is_semantic, dq_special;

    assign c = cmd_item.char_byte;
    assign is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    assign is_semantic = (c == CH_PIPE) || (c == CH_AMP) || (c == CH_SEMI) || (c == CH_LT)
                      || (c == CH_GT) || (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_STAR)
                      || (c == CH_QMARK) || (c == CH_LBRK) || ((c == CH_HASH) && !wopen_reg);
    assign dq_special = (c == CH_DQ) || (c == CH_BS) || (c == CH_DOLLAR) || (c == CH_BTICK);

    always_comb
    begin
        quote_next = quote_reg;
        esc_next   = esc_reg;
        wopen_next = wopen_reg;
        wlen_next  = wlen_reg;
        wnul_next  = wnul_reg;
        wdone_next = wdone_reg;
        bused_next = bused_reg;
        fwe_next   = fwe_reg;
        skip_next  = skip_reg;
        nbytes     = 2'd0;
        b0         = c;
        b1         = c;
        err_v      = 1'b0;
        err_c      = ERR_EXPANSION;
        fin_req    = 1'b0;
        wend       = 1'b0;
        accept     = 1'b0;
        remaining  = '0;

        // byte decode
        if (cmd_item.has_char)
        begin
            if (esc_reg != ESC_NONE)
            begin
                esc_next = ESC_NONE;
                if ((c == CH_LF) || (c == CH_CR))
                begin
                    err_v = 1'b1;
                    err_c = ERR_CONTINUE;
                end
                else if ((esc_reg == ESC_DOUBLE) && !dq_special)
                begin
                    nbytes = 2'd2;
                    b0     = CH_BS;
                end
                else
                begin
                    nbytes = 2'd1;
                end
            end
            else if (quote_reg == Q_SINGLE)
            begin
                if (c == CH_SQ)
                    quote_next = Q_UNQUOTED;
                else
                    nbytes = 2'd1;
            end
            else if (quote_reg == Q_DOUBLE)
            begin
                priority if (c == CH_DQ)
                    quote_next = Q_UNQUOTED;
                else if ((c == CH_DOLLAR) || (c == CH_BTICK))
                begin
                    err_v = 1'b1;
                    err_c = ERR_EXPANSION;
                end
                else if (c == CH_BS)
                    esc_next = ESC_DOUBLE;
                else
                    nbytes = 2'd1;
            end
            else
            begin
                priority if (is_space)
                    fin_req = 1'b1;
                else if (c == CH_SQ)
                begin
                    quote_next = Q_SINGLE;
                    wopen_next = 1'b1;
                end
                else if (c == CH_DQ)
                begin
                    quote_next = Q_DOUBLE;
                    wopen_next = 1'b1;
                end
                else if (c == CH_BS)
                begin
                    wopen_next = 1'b1;
                    esc_next   = ESC_PLAIN;
                end
                else if ((c == CH_DOLLAR) || (c == CH_BTICK))
                begin
                    err_v = 1'b1;
                    err_c = ERR_EXPANSION;
                end
                else if (is_semantic)
                begin
                    err_v = 1'b1;
                    err_c = ERR_SEMANTICS;
                end
                else
                begin
                    wopen_next = 1'b1;
                    nbytes     = 2'd1;
                end
            end
        end

        // length and NUL tracking of the emitted bytes
        wlen_sum = wlen_reg + LEN_W'(nbytes);
        wlen_e   = (wlen_sum > LEN_CAP) ? LEN_CAP : wlen_sum;
        wnul_e   = wnul_reg || ((nbytes != 2'd0) && (b1 == 8'h00))
                 || ((nbytes == 2'd2) && (b0 == 8'h00));
        wlen_next = wlen_e;
        wnul_next = wnul_e;

        // end-of-command checks that come before finishing the word
        if (cmd_item.end_of_command && !err_v)
        begin
            priority if (esc_next != ESC_NONE)
            begin
                err_v = 1'b1;
                err_c = ERR_TRAIL_ESC;
            end
            else if (quote_next != Q_UNQUOTED)
            begin
                err_v = 1'b1;
                err_c = ERR_UNTERM;
            end
            else
                fin_req = 1'b1;
        end

        // word finish with limit checks
        if (fin_req && wopen_next)
        begin
            remaining = (bused_reg > budget_reg) ? 32'd0 : (budget_reg - bused_reg);
            priority if (wdone_reg >= max_words_reg)
            begin
                err_v = 1'b1;
                err_c = ERR_COUNT;
            end
            else if (wlen_e > {1'b0, max_word_bytes_reg})
            begin
                err_v = 1'b1;
                err_c = ERR_BYTES;
            end
            else if (wnul_e)
            begin
                err_v = 1'b1;
                err_c = ERR_NUL;
            end
            else if (32'(wlen_e) > remaining)
            begin
                err_v = 1'b1;
                err_c = ERR_METADATA;
            end
            else
            begin
                wend       = 1'b1;
                bused_next = bused_reg + 32'(wlen_e);
                if ((wdone_reg == 16'd0) && (wlen_e == '0))
                    fwe_next = 1'b1;
                if (wdone_reg != 16'hFFFF)
                    wdone_next = wdone_reg + 16'd1;
                wopen_next = 1'b0;
                wlen_next  = '0;
                wnul_next  = 1'b0;
            end
        end

        if (cmd_item.end_of_command && !err_v)
        begin
            if ((wdone_next == 16'd0) || fwe_next)
            begin
                err_v = 1'b1;
                err_c = ERR_COMPILER;
            end
            else
                accept = 1'b1;
        end

        // command finished or failed: clear and maybe drop until its end
        if (err_v || accept)
        begin
            quote_next = Q_UNQUOTED;
            esc_next   = ESC_NONE;
            wopen_next = 1'b0;
            wlen_next  = '0;
            wnul_next  = 1'b0;
            wdone_next = '0;
            bused_next = '0;
            fwe_next   = 1'b0;
            skip_next  = err_v && !cmd_item.end_of_command;
        end

        bundle.slots[SLOT_BYTE0] = (nbytes != 2'd0);
        bundle.slots[SLOT_BYTE1] = (nbytes == 2'd2);
        bundle.slots[SLOT_WEND]  = wend;
        bundle.slots[SLOT_FINAL] = err_v || accept;
        bundle.byte0       = (nbytes == 2'd2) ? b0 : b1;
        bundle.byte1       = b1;
        bundle.word_index  = wdone_reg;
        bundle.final_error = err_v;
        bundle.fault_code  = err_c;

        // items of a failed command are dropped; its end item ends the dropping
        if (skip_reg)
        begin
            quote_next   = quote_reg;
            esc_next     = esc_reg;
            wopen_next   = wopen_reg;
            wlen_next    = wlen_reg;
            wnul_next    = wnul_reg;
            wdone_next   = wdone_reg;
            bused_next   = bused_reg;
            fwe_next     = fwe_reg;
            skip_next    = !cmd_item.end_of_command;
            bundle.slots = '0;
        end
    end

    assign bundle_valid = take && (bundle.slots != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_words_reg      <= MAX_WORDS_RESET;
            max_word_bytes_reg <= MAX_WORD_BYTES_RESET;
            budget_reg         <= BUDGET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_WORDS:      max_words_reg      <= cfg_data[15:0];
                CFG_MAX_WORD_BYTES: max_word_bytes_reg <= cfg_data[19:0];
                CFG_BUDGET:         budget_reg         <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg <= Q_UNQUOTED;
            esc_reg   <= ESC_NONE;
            wopen_reg <= 1'b0;
            wlen_reg  <= '0;
            wnul_reg  <= 1'b0;
            wdone_reg <= '0;
            bused_reg <= '0;
            fwe_reg   <= 1'b0;
            skip_reg  <= 1'b0;
        end
        else if (take)
        begin
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            wopen_reg <= wopen_next;
            wlen_reg  <= wlen_next;
            wnul_reg  <= wnul_next;
            wdone_reg <= wdone_next;
            bused_reg <= bused_next;
            fwe_reg   <= fwe_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

[sv/rsws_queue.sv]
// Short queue of result bundles between the front and back parts.
`timescale 1ns / 1ps

module rsws_queue
    import rsws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  rsws_bundle_t wr_data,
    input  logic         rd_en,
    output rsws_bundle_t rd_data,
    output logic         full,
    output logic         empty
);

    rsws_bundle_t      mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[sv/rsws_back.sv]
// Back part: walks the slots of the head bundle and presents one result at a time.
`timescale 1ns / 1ps

module rsws_back
    import rsws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         head_valid,
    input  rsws_bundle_t head,
    input  logic         pop,
    output rsws_out_t    result,
    output logic         head_done
);

    logic [NSLOTS-1:0] done_reg, done_next;
    logic [NSLOTS-1:0] pending, cur;
    logic              take;

    assign pending = head.slots & ~done_reg;
    assign cur     = pending & (~pending + 1'b1);
    assign take    = pop && head_valid;
    assign head_done = take && ((pending & ~cur) == '0);

    always_comb
    begin
        result.kind       = KIND_BYTE;
        result.out_byte   = 8'h00;
        result.word_index = 16'h0000;
        result.fault_code = ERR_EXPANSION;
        result.last       = 1'b0;
        priority if (cur[SLOT_BYTE0])
        begin
            result.out_byte   = head.byte0;
            result.word_index = head.word_index;
        end
        else if (cur[SLOT_BYTE1])
        begin
            result.out_byte   = head.byte1;
            result.word_index = head.word_index;
        end
        else if (cur[SLOT_WEND])
        begin
            result.kind       = KIND_WEND;
            result.word_index = head.word_index;
        end
        else if (head.final_error)
        begin
            result.kind       = KIND_ERROR;
            result.fault_code = head.fault_code;
            result.last       = 1'b1;
        end
        else
        begin
            result.kind = KIND_ACCEPT;
            result.last = 1'b1;
        end
    end

    always_comb
    begin
        done_next = done_reg;
        if (head_done)
            done_next = '0;
        else if (take)
            done_next = done_reg | cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= '0;
        else
            done_reg <= done_next;
    end

endmodule

[dv/testbench.sv]
// Self-checking testbench for the restricted shell word splitter.
`timescale 1ns / 1ps

module testbench;
    import rsws_pkg::*;

    // Run control
    localparam int REPORT_CAP   = 200;  // stop printing mismatches after this many
    localparam int STALL_LIMIT  = 2000; // cycles without any handshake before giving up
    localparam int QUIET_CYCLES = 8;    // margin for items that leave no result behind
    localparam int NO_ERROR     = -1;
    localparam int unsigned WORD_LEN_CAP = 32'h0010_0000;

    // Register index with no register behind it
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // Characters the splitter treats specially
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TICK   = 8'h60;

    localparam string PLAIN_SET = "abcdefxyzABZ0189-_./=%+,:@~";
    localparam string NOISE_SET = "|&;<>()*?[#$'\"\\ \t\r\n";

    typedef enum logic [1:0] {QM_PLAIN, QM_SINGLE, QM_DOUBLE} quote_mode_t;
    typedef enum logic [1:0] {ESC_OFF, ESC_BARE, ESC_IN_DQ} escape_t;

    // DUT ports
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       full;
    rsws_in_t   cmd_item  = '0;
    logic       empty;
    logic       pop       = 1'b0;
    rsws_out_t  result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_MAX_WORDS;
    logic [31:0] cfg_data = '0;

    // Stimulus and scoreboard
    rsws_in_t  item_queue[$];        // items waiting for the driver
    rsws_out_t expected_results[$];  // predicted results, oldest first
    rsws_out_t oldest_expected;
    bit        item_taken = 1'b0;    // an item was accepted at the last rising edge
    bit        calm       = 1'b0;    // no idling on either side while set
    int        failures        = 0;
    int        items_queued    = 0;
    int        items_taken     = 0;
    int        results_checked = 0;
    int        accepted_cmds   = 0;
    int        rejected_cmds   = 0;
    int        stall_cycles    = 0;
    logic [15:0] codes_seen    = '0;

    // Splitter state as the predictor sees it
    logic [15:0] max_words_cfg = MAX_WORDS_RESET;
    logic [19:0] max_bytes_cfg = MAX_WORD_BYTES_RESET;
    logic [31:0] budget_cfg    = BUDGET_RESET;
    quote_mode_t quote_phase   = QM_PLAIN;
    escape_t     escape_state  = ESC_OFF;
    bit          word_open     = 1'b0;
    int unsigned word_len      = 0;
    bit          word_nul      = 1'b0;
    logic [15:0] words_done    = '0;
    logic [31:0] bytes_used    = '0;
    bit          first_empty   = 1'b0;
    bit          skipping      = 1'b0;

    restricted_shell_word_splitter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd_item  (cmd_item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Word splitting predictor
    // ------------------------------------------------------------------

    function automatic void put_result(logic [1:0] kind, logic [7:0] out_byte,
                                       logic [15:0] word_index, logic [3:0] code,
                                       logic last);
        rsws_out_t r;
        r.kind       = kind;
        r.out_byte   = out_byte;
        r.word_index = word_index;
        r.fault_code = code;
        r.last       = last;
        expected_results.insert(expected_results.size(), r);
        if (kind == KIND_ACCEPT)
            accepted_cmds++;
        if (kind == KIND_ERROR)
        begin
            rejected_cmds++;
            codes_seen[code] = 1'b1;
        end
    endfunction

    // Drop everything the current command has built up
    function automatic void clear_command();
        quote_phase  = QM_PLAIN;
        escape_state = ESC_OFF;
        word_open    = 1'b0;
        word_len     = 0;
        word_nul     = 1'b0;
        words_done   = '0;
        bytes_used   = '0;
        first_empty  = 1'b0;
        skipping     = 1'b0;
    endfunction

    function automatic void emit_char(logic [7:0] c);
        put_result(KIND_BYTE, c, words_done, 4'd0, 1'b0);
        if (word_len < WORD_LEN_CAP)
            word_len++;
        if (c == 8'h00)
            word_nul = 1'b1;
    endfunction

    // Close the open word against all limits; the first failing limit wins
    function automatic int close_word();
        int unsigned room;
        if (!word_open)
            return NO_ERROR;
        if (words_done >= max_words_cfg)
            return ERR_COUNT;
        if (word_len > max_bytes_cfg)
            return ERR_BYTES;
        if (word_nul)
            return ERR_NUL;
        // a budget lowered below what is already used leaves no room at all
        room = (bytes_used > budget_cfg) ? 0 : budget_cfg - bytes_used;
        if (word_len > room)
            return ERR_METADATA;
        bytes_used += word_len;
        put_result(KIND_WEND, 8'h00, words_done, 4'd0, 1'b0);
        if (words_done == 0 && word_len == 0)
            first_empty = 1'b1;
        if (words_done != 16'hFFFF)
            words_done++;
        word_open = 1'b0;
        word_len  = 0;
        word_nul  = 1'b0;
        return NO_ERROR;
    endfunction

    function automatic int consume_char(logic [7:0] c);
        escape_t mode;
        if (escape_state != ESC_OFF)
        begin
            mode = escape_state;
            escape_state = ESC_OFF;
            if (c == CH_LF || c == CH_CR)
                return ERR_CONTINUE;
            // inside double quotes the backslash stays unless it escapes one of four
            if (mode == ESC_IN_DQ && !(c inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_TICK}))
                emit_char(CH_BSLASH);
            emit_char(c);
            return NO_ERROR;
        end
        if (quote_phase == QM_SINGLE)
        begin
            if (c == CH_SQUOTE)
                quote_phase = QM_PLAIN;
            else
                emit_char(c);
            return NO_ERROR;
        end
        if (quote_phase == QM_DOUBLE)
        begin
            if (c == CH_DQUOTE)
                quote_phase = QM_PLAIN;
            else if (c == CH_DOLLAR || c == CH_TICK)
                return ERR_EXPANSION;
            else if (c == CH_BSLASH)
                escape_state = ESC_IN_DQ;
            else
                emit_char(c);
            return NO_ERROR;
        end
        if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})
            return close_word();
        if (c == CH_SQUOTE || c == CH_DQUOTE)
        begin
            quote_phase = (c == CH_SQUOTE) ? QM_SINGLE : QM_DOUBLE;
            word_open = 1'b1;
            return NO_ERROR;
        end
        if (c == CH_BSLASH)
        begin
            word_open = 1'b1;
            escape_state = ESC_BARE;
            return NO_ERROR;
        end
        if (c == CH_DOLLAR || c == CH_TICK)
            return ERR_EXPANSION;
        // a hash only starts a comment where no word is open
        if (c inside {"|", "&", ";", "<", ">", "(", ")", "*", "?", "["} ||
            (c == CH_HASH && !word_open))
            return ERR_SEMANTICS;
        word_open = 1'b1;
        emit_char(c);
        return NO_ERROR;
    endfunction

    function automatic int close_command();
        int code;
        if (escape_state != ESC_OFF)
            return ERR_TRAIL_ESC;
        if (quote_phase != QM_PLAIN)
            return ERR_UNTERM;
        code = close_word();
        if (code != NO_ERROR)
            return code;
        if (words_done == 0 || first_empty)
            return ERR_COMPILER;
        return NO_ERROR;
    endfunction

    // Advance the splitter by one accepted item and queue what it must produce
    function automatic void predict_item(rsws_in_t it);
        int code;
        code = NO_ERROR;
        if (skipping)
        begin
            // after an error only the end item matters, and it only clears
            if (it.end_of_command)
                clear_command();
            return;
        end
        if (it.has_char)
            code = consume_char(it.char_byte);
        if (code == NO_ERROR && it.end_of_command)
        begin
            code = close_command();
            if (code == NO_ERROR)
            begin
                put_result(KIND_ACCEPT, 8'h00, 16'd0, 4'd0, 1'b1);
                clear_command();
                return;
            end
        end
        if (code != NO_ERROR)
        begin
            put_result(KIND_ERROR, 8'h00, 16'd0, code[3:0], 1'b1);
            clear_command();
            if (!it.end_of_command)
                skipping = 1'b1;
        end
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            failures++;
            if (failures <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next pending item at the falling edge, hold it until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (!push || item_taken)
        begin
            if (item_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 16))
            begin
                push     <= 1'b1;
                cmd_item <= item_queue.pop_front();
            end
            else
                push <= 1'b0;
        end
    end

    // Consumer: stall the result side at random, never while calm
    always @(negedge clk)
        pop <= rst_n && (calm || $urandom_range(0, 99) >= 16);

    // ------------------------------------------------------------------
    // Monitor: check popped results, predict accepted items, watch for a hang
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        // check first: a result never belongs to the item taken at the same edge
        if (rst_n && pop && !empty)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_CAP)
                    $display("%0t: expected no result, got kind %0d byte %02h word %0d code %0d last %0b",
                             $time, result.kind, result.out_byte, result.word_index,
                             result.fault_code, result.last);
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                check_field("kind", oldest_expected.kind, result.kind);
                check_field("out_byte", oldest_expected.out_byte, result.out_byte);
                check_field("word_index", oldest_expected.word_index, result.word_index);
                check_field("fault_code", oldest_expected.fault_code, result.fault_code);
                check_field("last", oldest_expected.last, result.last);
            end
        end

        item_taken = rst_n && push && !full;
        if (item_taken)
        begin
            items_taken++;
            predict_item(cmd_item);
        end

        if (item_taken || (rst_n && pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, expected_results.size());
            $display("restricted_shell_word_splitter test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one item; a byte that is not flagged valid gets random content
    function automatic void add_item(logic [7:0] c, bit has, bit eoc);
        rsws_in_t it;
        if (!has)
            c = 8'($urandom_range(0, 255));
        it.char_byte      = c;
        it.has_char       = has;
        it.end_of_command = eoc;
        item_queue.insert(item_queue.size(), it);
        items_queued++;
    endfunction

    function automatic void add_text(string s, bit end_on_last);
        for (int i = 0; i < s.len(); i++)
            add_item(s[i], 1'b1, end_on_last && i == s.len() - 1);
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(128, 255));
        return PLAIN_SET[$urandom_range(0, PLAIN_SET.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_noise();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return NOISE_SET[$urandom_range(0, NOISE_SET.len() - 1)];
        if (r == 6)
            return CH_TICK;
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one command: a well-formed one with random content, sometimes broken in
    // one place, or a short burst of noise
    function automatic void add_command(bit well_formed);
        logic [7:0] text[$];
        logic [7:0] c;
        int nwords;
        int nsegs;
        int len;
        bit end_on_last;
        if (well_formed)
        begin
            if ($urandom_range(0, 4) == 0)
                text.insert(text.size(), pick_space());
            nwords = $urandom_range(1, 4);
            for (int w = 0; w < nwords; w++)
            begin
                if (w > 0)
                    repeat ($urandom_range(1, 2)) text.insert(text.size(), pick_space());
                nsegs = $urandom_range(1, 3);
                for (int s = 0; s < nsegs; s++)
                begin
                    len = $urandom_range(0, 4);
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            // bare characters; a hash inside a word is ordinary
                            for (int k = 0; k <= len; k++)
                                text.insert(text.size(),
                                            (k > 0 && $urandom_range(0, 9) == 0) ?
                                            CH_HASH : pick_plain());
                        end
                        1:
                        begin
                            text.insert(text.size(), CH_SQUOTE);
                            repeat (len)
                            begin
                                do c = 8'($urandom_range(0, 255)); while (c == CH_SQUOTE);
                                text.insert(text.size(), c);
                            end
                            text.insert(text.size(), CH_SQUOTE);
                        end
                        2:
                        begin
                            text.insert(text.size(), CH_DQUOTE);
                            repeat (len)
                            begin
                                case ($urandom_range(0, 6))
                                    0:
                                    begin
                                        text.insert(text.size(), CH_BSLASH);
                                        case ($urandom_range(0, 4))
                                            0: text.insert(text.size(), CH_DQUOTE);
                                            1: text.insert(text.size(), CH_BSLASH);
                                            2: text.insert(text.size(), CH_DOLLAR);
                                            3: text.insert(text.size(), CH_TICK);
                                            default: text.insert(text.size(), pick_plain());
                                        endcase
                                    end
                                    1: text.insert(text.size(), CH_SPACE);
                                    2: text.insert(text.size(), CH_SQUOTE);
                                    3: text.insert(text.size(), 8'h7C);
                                    default: text.insert(text.size(), pick_plain());
                                endcase
                            end
                            text.insert(text.size(), CH_DQUOTE);
                        end
                        default:
                        begin
                            text.insert(text.size(), CH_BSLASH);
                            do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
                            text.insert(text.size(), c);
                        end
                    endcase
                end
            end
            if ($urandom_range(0, 4) == 0)
                text.insert(text.size(), pick_space());
            if ($urandom_range(0, 5) == 0)
                text[$urandom_range(0, text.size() - 1)] = pick_noise();
        end
        else
            repeat ($urandom_range(1, 8)) text.insert(text.size(), pick_noise());

        end_on_last = 1'($urandom_range(0, 1));
        foreach (text[i])
        begin
            if ($urandom_range(0, 15) == 0)
                add_item(8'h00, 1'b0, 1'b0);
            add_item(text[i], 1'b1, end_on_last && i == text.size() - 1);
        end
        if (!end_on_last)
            add_item(8'h00, 1'b0, 1'b1);
    endfunction

    // Keep a few commands in flight until enough items have been queued
    task automatic run_random(int target);
        int goal;
        goal = items_queued + target;
        while (items_queued < goal)
        begin
            while (item_queue.size() > 12)
                @(posedge clk);
            add_command($urandom_range(0, 99) >= 15);
        end
    endtask

    // Hold until every item is taken and every result is back, then let
    // the tail of result-free items settle
    task automatic wait_for_drain();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (item_queue.size() != 0 || push || expected_results.size() != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_MAX_WORDS:      max_words_cfg = data[15:0];
            CFG_MAX_WORD_BYTES: max_bytes_cfg = data[19:0];
            CFG_BUDGET:         budget_cfg    = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write all three limits; bits above each register's width carry junk
    task automatic set_limits(logic [15:0] words, logic [19:0] bytes, logic [31:0] budget);
        logic [31:0] junk;
        junk = $urandom;
        write_register(CFG_MAX_WORDS, {junk[15:0], words});
        write_register(CFG_MAX_WORD_BYTES, {junk[27:16], bytes});
        write_register(CFG_BUDGET, budget);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one word through every quoting form: high byte in single quotes,
        // bare escape, kept backslash and escaped quote inside double quotes
        add_item(CH_SQUOTE, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(CH_SQUOTE, 1'b1, 1'b0);
        add_text("\\q\"\\x\\\"\"", 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        // byte and end of command on the same item
        add_text("a b", 1'b1);
        // expansion mid-command, then ignored items up to the end marker
        add_text("$", 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_text("a", 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        // errors raised on the end item itself
        add_text("#", 1'b1);
        add_text("\\", 1'b1);
        add_text("\"", 1'b1);
        // line continuation
        add_text("\\\n", 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        // empty first word, no words at all, NUL inside a word
        add_text("''", 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h00, 1'b1, 1'b1);

        run_random(70);

        // tightest limits: almost every word fails
        wait_for_drain();
        set_limits(16'd1, 20'd1, 32'd0);
        run_random(35);

        // small limits, and a budget cut below what the command already used
        wait_for_drain();
        set_limits(16'd3, 20'd4, 32'd10);
        add_text("ab cd", 1'b0);
        wait_for_drain();
        write_register(CFG_BUDGET, 32'd1);
        add_item(8'h00, 1'b0, 1'b1);
        wait_for_drain();
        write_register(CFG_BUDGET, 32'd10);
        run_random(60);

        // widest limits at full rate on both sides
        wait_for_drain();
        set_limits(16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
        write_register(CFG_SPARE, $urandom);
        calm = 1'b1;
        run_random(50);
        wait_for_drain();
        calm = 1'b0;

        // random small limits, draining between settings
        repeat (4)
        begin
            set_limits(16'($urandom_range(1, 6)), 20'($urandom_range(1, 8)),
                       32'($urandom_range(0, 30)));
            run_random(18);
            wait_for_drain();
        end

        failures += expected_results.size();
        $display("Sent %0d items, checked %0d results: %0d commands accepted, %0d rejected",
                 items_taken, results_checked, accepted_cmds, rejected_cmds);
        $display("Distinct error codes raised: %0d of 10", $countones(codes_seen));
        if (failures == 0)
            $display("restricted_shell_word_splitter test passed");
        else
            $display("restricted_shell_word_splitter test failed");
        $finish;
    end

endmodule
